/* sv/tar_size_field_decoder_assert.svh */
// Assertion macros for the tar size field decoder.
`ifndef TAR_SIZE_FIELD_DECODER_ASSERT_SVH
`define TAR_SIZE_FIELD_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define TSFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TSFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/tsfd_pkg.sv */
// Package: beat types, parse phases and register map of the tar size field decoder.
package tsfd_pkg;

    typedef struct packed {
        logic [7:0] field_byte;
        logic       last_byte;
    } byte_beat_t;

    typedef struct packed {
        logic [63:0] field_value;
        logic [23:0] record_bytes;
        logic        was_saturated;
    } result_beat_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] value;
    } value_beat_t;

    typedef enum logic [2:0] {
        PH_FIRST  = 3'd0,
        PH_B256   = 3'd1,
        PH_SKIP   = 3'd2,
        PH_DIGITS = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    localparam int unsigned PADDR_W     = 3;
    localparam logic        REG_ALIGN   = 1'b0;
    localparam logic [3:0]  ALIGN_RESET = 4'd9;

endpackage

/* sv/tsfd_regs.sv */
// Configuration register block: APB-style access to align_log2.
module tsfd_regs
    import tsfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [3:0]         align_log2
);

    logic [3:0] align_reg;
    logic [3:0] align_next;
    logic       reg_index;

    assign reg_index = paddr[2];
    assign pready    = 1'b1;

    always_comb
    begin
        align_next = align_reg;
        if (psel && penable && pwrite && (reg_index == REG_ALIGN))
        begin
            align_next = pwdata[3:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            align_reg <= ALIGN_RESET;
        end
        else
        begin
            align_reg <= align_next;
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (reg_index == REG_ALIGN)
        begin
            prdata = {28'd0, align_reg};
        end
    end

    assign align_log2 = align_reg;

endmodule

/* sv/tsfd_parse.sv */
// Field parser: phase and accumulator per byte, value beat on the last byte.
module tsfd_parse
    import tsfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  byte_beat_t  byte_beat,
    output value_beat_t value_beat,
    input  logic        value_ready
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [63:0] accum_reg;
    logic [63:0] accum_next;
    logic        val_valid_reg;
    logic        val_valid_next;
    logic [63:0] val_value_reg;
    logic [63:0] val_value_next;
    phase_t      phase_upd;
    logic [63:0] accum_upd;
    logic        accept;
    logic        is_octal;
    logic [7:0]  b;
    logic [63:0] accum_shift;

    assign b           = byte_beat.field_byte;
    assign byte_ready  = !val_valid_reg || value_ready;
    assign accept      = byte_valid && byte_ready;
    assign is_octal    = b inside {[8'h30:8'h37]};
    assign accum_shift = {accum_reg[60:0], b[2:0]};

    always_comb
    begin
        phase_upd = phase_reg;
        accum_upd = accum_reg;
        case (phase_reg)
            PH_FIRST:
            begin
                if (b[7])
                begin
                    accum_upd = {57'd0, b[6:0]};
                    phase_upd = PH_B256;
                end
                else if (is_octal)
                begin
                    accum_upd = accum_shift;
                    phase_upd = PH_DIGITS;
                end
                else if (b == 8'h00 || b == 8'h20)
                begin
                    phase_upd = PH_DONE;
                end
                else
                begin
                    phase_upd = PH_SKIP;
                end
            end
            PH_B256:
            begin
                accum_upd = {accum_reg[55:0], b};
            end
            PH_SKIP:
            begin
                if (is_octal)
                begin
                    accum_upd = accum_shift;
                    phase_upd = PH_DIGITS;
                end
                else if (b == 8'h00 || b == 8'h20)
                begin
                    phase_upd = PH_DONE;
                end
            end
            PH_DIGITS:
            begin
                if (is_octal)
                begin
                    accum_upd = accum_shift;
                end
                else
                begin
                    phase_upd = PH_DONE;
                end
            end
            default:
            begin
                phase_upd = phase_reg;
            end
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        accum_next     = accum_reg;
        val_value_next = val_value_reg;
        val_valid_next = val_valid_reg && !value_ready;
        if (accept)
        begin
            if (byte_beat.last_byte)
            begin
                phase_next     = PH_FIRST;
                accum_next     = 64'd0;
                val_valid_next = 1'b1;
                val_value_next = accum_upd;
            end
            else
            begin
                phase_next = phase_upd;
                accum_next = accum_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            accum_reg     <= 64'd0;
            val_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            accum_reg     <= accum_next;
            val_valid_reg <= val_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_value_reg <= val_value_next;
    end

    assign value_beat.valid = val_valid_reg;
    assign value_beat.value = val_value_reg;

endmodule

/* sv/tsfd_round.sv */
// Rounding stage: align up, saturate, result register.
module tsfd_round
    import tsfd_pkg::*;
#(
    parameter int unsigned SIZE_LIMIT_BITS = 24
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  value_beat_t  value_beat,
    output logic         value_ready,
    input  logic [3:0]   align_log2,
    output logic         result_valid,
    input  logic         result_ready,
    output result_beat_t result_beat
);

    localparam logic [63:0] LIMIT_M1 = (64'd1 << SIZE_LIMIT_BITS) - 64'd1;

    logic         out_valid_reg;
    logic         out_valid_next;
    result_beat_t out_beat_reg;
    result_beat_t out_beat_next;
    logic [15:0]  mask;
    logic [15:0]  pad;
    logic [63:0]  size;
    logic         sat;

    assign value_ready = !out_valid_reg || result_ready;
    assign mask        = (16'd1 << align_log2) - 16'd1;
    assign pad         = (16'd0 - value_beat.value[15:0]) & mask;
    assign size        = value_beat.value + {48'd0, pad};
    assign sat         = |(size >> SIZE_LIMIT_BITS);

    always_comb
    begin
        out_valid_next = out_valid_reg && !result_ready;
        out_beat_next  = out_beat_reg;
        if (value_beat.valid && value_ready)
        begin
            out_valid_next              = 1'b1;
            out_beat_next.field_value   = value_beat.value;
            out_beat_next.record_bytes  = sat ? LIMIT_M1[23:0] : size[23:0];
            out_beat_next.was_saturated = sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_beat_reg <= out_beat_next;
    end

    assign result_valid = out_valid_reg;
    assign result_beat  = out_beat_reg;

endmodule

/* sv/tar_size_field_decoder.sv */
// Top level of the tar size field decoder.
// The last accepted byte of a field loads the parser's value register; that beat then loads the result register.
// Throughput: one byte beat per cycle while byte_ready holds; it drops while the value stage is full and stalled.
// Result register and value stage decouple the byte and result channels.
// Reset: parse phase to first byte, accumulator to 0, beats dropped, align_log2 to 9.
module tar_size_field_decoder
    import tsfd_pkg::*;
#(
    parameter int unsigned SIZE_LIMIT_BITS = 24
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  byte_beat_t         byte_beat,
    output logic               result_valid,
    input  logic               result_ready,
    output result_beat_t       result_beat,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

`include "tar_size_field_decoder_assert.svh"

    localparam logic [63:0] SAT_VALUE = (64'd1 << SIZE_LIMIT_BITS) - 64'd1;

    logic [3:0]  align_log2;
    value_beat_t value_beat;
    logic        value_ready;

    tsfd_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .align_log2 (align_log2)
    );

    tsfd_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .byte_beat   (byte_beat),
        .value_beat  (value_beat),
        .value_ready (value_ready)
    );

    tsfd_round #(
        .SIZE_LIMIT_BITS (SIZE_LIMIT_BITS)
    ) u_round (
        .clk          (clk),
        .rst_n        (rst_n),
        .value_beat   (value_beat),
        .value_ready  (value_ready),
        .align_log2   (align_log2),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_beat  (result_beat)
    );

    `TSFD_ASSERT_NEXT(a_last_to_value, byte_valid && byte_ready && byte_beat.last_byte, value_beat.valid, "last byte did not load the value stage")
    `TSFD_ASSERT_NEXT(a_value_to_result, value_beat.valid && value_ready, result_valid, "value beat did not reach the result register")
    `TSFD_ASSERT_NOW(a_sat_value, result_valid && result_beat.was_saturated, result_beat.record_bytes == SAT_VALUE[23:0], "saturated size is not the limit")

endmodule
